// ----- rtl/core/sfcd_pkg.sv -----
// ----------------------------------------------------------------------------
// sfcd_pkg
// Shared types, constants and the CRC-8 byte update for the frame decoder.
// ----------------------------------------------------------------------------
package sfcd_pkg;

   localparam int unsigned NumFields = 6;
   localparam logic [7:0]  MinLength = 8'd7;
   localparam logic [8:0]  PolyFull  = 9'h18D;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_CRC_ERR = 2'd1,
      STATUS_SHORT   = 2'd2
   } status_type;

   typedef struct packed {
      status_type status;
      logic [7:0] frame_length;
      logic [7:0] node_id;
      logic [7:0] temp_whole;
      logic [7:0] temp_hundredths;
      logic [7:0] humi_whole;
      logic [7:0] humi_hundredths;
      logic [7:0] relay_state;
   } result_type;

   // Shifts one byte, MSB first, into the remainder of a division by x^8+x^7+x^3+x^2+1.
   function automatic logic [7:0] crc8_step(logic [7:0] rem, logic [7:0] data);
      logic [8:0] r;
      r = {1'b0, rem};
      for (int k = 0; k < 8; k++) begin
         r = {r[7:0], data[7-k]};
         if (r[8]) begin
            r = r ^ PolyFull;
         end
      end
      return r[7:0];
   endfunction

endpackage

// ----- rtl/core/sensor_frame_crc8_decoder.sv -----
// ----------------------------------------------------------------------------
// sensor_frame_crc8_decoder
// Decodes CRC-8 checked sensor frames arriving one byte per item.
// ----------------------------------------------------------------------------
//   channel   ports                         direction   content
//   req       req_valid/req_ready           in          one frame byte
//   rsp       rsp_valid/rsp_ready           out         status, length, fields
//
// One byte is taken every cycle while req_ready is high; the CRC update is unrolled over the byte.
// A frame's result is registered in the result register or, while that is
// held, in the one-entry skid stage behind it, which keeps req_ready
// high while one result waits; req_ready drops only with two results held.
// Synchronous reset returns the decoder to waiting for a length byte.
// ----------------------------------------------------------------------------
module sensor_frame_crc8_decoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_status,
   output logic [7:0] rsp_frame_length,
   output logic [7:0] rsp_node_id,
   output logic [7:0] rsp_temp_whole,
   output logic [7:0] rsp_temp_hundredths,
   output logic [7:0] rsp_humi_whole,
   output logic [7:0] rsp_humi_hundredths,
   output logic [7:0] rsp_relay_state
);

   logic                 byte_accept;
   logic                 res_valid;
   sfcd_pkg::result_type res_data;
   sfcd_pkg::result_type rsp_data;

   assign byte_accept = req_valid && req_ready;

   sfcd_parse u_parse (
      .clock       (clock),
      .reset       (reset),
      .byte_accept (byte_accept),
      .data_byte   (req_data_byte),
      .res_valid   (res_valid),
      .res_data    (res_data)
   );

   sfcd_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res_data),
      .space     (req_ready),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   assign rsp_status          = rsp_data.status;
   assign rsp_frame_length    = rsp_data.frame_length;
   assign rsp_node_id         = rsp_data.node_id;
   assign rsp_temp_whole      = rsp_data.temp_whole;
   assign rsp_temp_hundredths = rsp_data.temp_hundredths;
   assign rsp_humi_whole      = rsp_data.humi_whole;
   assign rsp_humi_hundredths = rsp_data.humi_hundredths;
   assign rsp_relay_state     = rsp_data.relay_state;

`ifndef SYNTH
   a_short_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_frame_length < sfcd_pkg::MinLength)
      |-> rsp_status == sfcd_pkg::STATUS_SHORT)
      else $error("short frame not flagged as short");

   a_fields_zeroed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != sfcd_pkg::STATUS_OK)
      |-> (rsp_node_id == 8'd0) && (rsp_temp_whole == 8'd0)
          && (rsp_temp_hundredths == 8'd0) && (rsp_humi_whole == 8'd0)
          && (rsp_humi_hundredths == 8'd0) && (rsp_relay_state == 8'd0))
      else $error("failed frame carries nonzero fields");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with no result waiting");
`endif

endmodule

// ----- rtl/core/sfcd_parse.sv -----
// ----------------------------------------------------------------------------
// sfcd_parse
// Frame tracking, CRC update and field capture; raises one result per frame.
// ----------------------------------------------------------------------------
module sfcd_parse (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   byte_accept,
   input  logic [7:0]             data_byte,
   output logic                   res_valid,
   output sfcd_pkg::result_type   res_data
);

   logic [7:0] pos_ff, pos_in;
   logic [7:0] len_ff, len_in;
   logic [7:0] crc_ff, crc_in;
   logic [7:0] fields_ff [sfcd_pkg::NumFields];
   logic [7:0] fields_in [sfcd_pkg::NumFields];
   logic       done;
   logic       status_ok;
   sfcd_pkg::status_type status;

   always_comb begin
      pos_in = pos_ff;
      len_in = len_ff;
      crc_in = crc_ff;
      fields_in = fields_ff;
      done = 1'b0;
      if (byte_accept) begin
         if (pos_ff == 8'd0) begin
            len_in = data_byte;
            crc_in = 8'd0;
            for (int i = 0; i < sfcd_pkg::NumFields; i++) begin
               fields_in[i] = 8'd0;
            end
            // Lengths of zero or one close the frame on the length byte itself.
            if (data_byte <= 8'd1) begin
               done = 1'b1;
            end else begin
               pos_in = 8'd1;
            end
         end else begin
            crc_in = sfcd_pkg::crc8_step(crc_ff, data_byte);
            for (int i = 0; i < sfcd_pkg::NumFields; i++) begin
               if (pos_ff == 8'(i + 1)) begin
                  fields_in[i] = data_byte;
               end
            end
            if ({1'b0, pos_ff} + 9'd1 >= {1'b0, len_ff}) begin
               done = 1'b1;
               pos_in = 8'd0;
            end else begin
               pos_in = pos_ff + 8'd1;
            end
         end
      end
   end

   always_comb begin
      if (len_in < sfcd_pkg::MinLength) begin
         status = sfcd_pkg::STATUS_SHORT;
      end else if (crc_in != 8'd0) begin
         status = sfcd_pkg::STATUS_CRC_ERR;
      end else begin
         status = sfcd_pkg::STATUS_OK;
      end
      status_ok = (status == sfcd_pkg::STATUS_OK);
      res_valid = done;
      res_data.status          = status;
      res_data.frame_length    = len_in;
      res_data.node_id         = status_ok ? fields_in[0] : 8'd0;
      res_data.temp_whole      = status_ok ? fields_in[1] : 8'd0;
      res_data.temp_hundredths = status_ok ? fields_in[2] : 8'd0;
      res_data.humi_whole      = status_ok ? fields_in[3] : 8'd0;
      res_data.humi_hundredths = status_ok ? fields_in[4] : 8'd0;
      res_data.relay_state     = status_ok ? fields_in[5] : 8'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= 8'd0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   // Length, remainder and fields are reloaded on every length byte.
   always_ff @(posedge clock) begin
      len_ff <= len_in;
      crc_ff <= crc_in;
      fields_ff <= fields_in;
   end

endmodule

// ----- rtl/core/sfcd_outbuf.sv -----
// ----------------------------------------------------------------------------
// sfcd_outbuf
// Result register with one skid entry, so the input side keeps moving while
// a finished result waits.
// ----------------------------------------------------------------------------
module sfcd_outbuf (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  sfcd_pkg::result_type   push_data,
   output logic                   space,
   output logic                   out_valid,
   input  logic                   out_ready,
   output sfcd_pkg::result_type   out_data
);

   logic                 out_valid_ff, out_valid_in;
   logic                 skid_valid_ff, skid_valid_in;
   sfcd_pkg::result_type out_ff, out_in;
   sfcd_pkg::result_type skid_ff, skid_in;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (!out_valid_ff || out_ready) begin
         // A held skid item is older than anything arriving, so it goes first.
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = push_data;
            out_valid_in = push;
         end
      end else if (push) begin
         skid_in       = push_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign space     = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

endmodule
